// ----- sv/slmrf_pkg.sv -----
`default_nettype none

package slmrf_pkg;

    // fixed field widths
    localparam int unsigned MASK_W   = 16;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned SECTOR_W = 6;
    localparam int unsigned LAYER_W  = 4;
    localparam int unsigned MODID_W  = 16;
    localparam int unsigned ROADNO_W = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_A_W  = 2;

    // input item kinds
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_HIT  = 2'd1,
        OP_EOE  = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_LAYER_COUNT    = 2'd0,
        CFG_ALLOWED_MISSES = 2'd1,
        CFG_SECTOR_COUNT   = 2'd2,
        CFG_WILDCARD       = 2'd3
    } cfg_idx_t;

    // control state of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // command broadcast to every sector cell
    typedef struct packed {
        logic                load;
        logic                hit;
        logic                eoe;
        logic                wild;
        logic [SECTOR_W-1:0] sector;
        logic [LAYER_W-1:0]  layer;
        logic [MASK_W-1:0]   lmask;
        logic [CNT_W-1:0]    need;
    } bcast_t;

    // per-sector scan word shifted along the chain
    typedef struct packed {
        logic              fire;
        logic [MASK_W-1:0] hit;
        logic [MASK_W-1:0] wild;
    } scan_t;

endpackage

`default_nettype wire

// ----- sv/slmrf_cell.sv -----
`default_nettype none

module slmrf_cell #(
    parameter int SECTOR_ID   = 0,
    parameter int MAX_LAYERS  = 16,
    parameter int MODULE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire slmrf_pkg::bcast_t      bc,
    input  wire logic [MODULE_BITS-1:0] module_val,
    input  wire logic                   shift_en,
    input  wire slmrf_pkg::scan_t       scan_in,
    output slmrf_pkg::scan_t            scan_out
);

    localparam int LIDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

    logic [MODULE_BITS-1:0]       entry_mem [MAX_LAYERS];
    logic [slmrf_pkg::MASK_W-1:0] wild_reg;
    logic [slmrf_pkg::MASK_W-1:0] hit_reg;
    slmrf_pkg::scan_t             scan_reg;

    logic                         mine;
    logic                         layer_ok;
    logic [LIDX_W-1:0]            lidx;
    logic [slmrf_pkg::MASK_W-1:0] lbit;
    logic                         match;
    logic [slmrf_pkg::MASK_W-1:0] h_eff;
    logic [slmrf_pkg::MASK_W-1:0] w_eff;
    logic [slmrf_pkg::CNT_W-1:0]  covered;

    // address decode and match against the stored id
    assign mine     = (bc.sector == slmrf_pkg::SECTOR_W'(SECTOR_ID));
    assign layer_ok = (32'(bc.layer) < MAX_LAYERS);
    assign lidx     = LIDX_W'(bc.layer);
    assign lbit     = slmrf_pkg::MASK_W'(1) << bc.layer;
    assign match    = layer_ok && (entry_mem[lidx] == module_val);

    // coverage of this sector at end of event
    assign h_eff   = hit_reg & bc.lmask;
    assign w_eff   = wild_reg & bc.lmask;
    assign covered = slmrf_pkg::CNT_W'($countones(h_eff | w_eff));

    // module id table row
    always_ff @(posedge clk)
    begin
        if (bc.load && mine && layer_ok)
        begin
            entry_mem[lidx] <= module_val;
        end
    end

    // wildcard, hit and scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wild_reg <= '0;
            hit_reg  <= '0;
            scan_reg <= '0;
        end
        else
        begin
            if (bc.load && mine && layer_ok)
            begin
                if (bc.wild)
                    wild_reg <= wild_reg | lbit;
                else
                    wild_reg <= wild_reg & ~lbit;
            end

            if (bc.eoe)
                hit_reg <= '0;
            else if (bc.hit && match)
                hit_reg <= hit_reg | lbit;

            if (bc.eoe)
            begin
                scan_reg.fire <= (covered >= bc.need);
                scan_reg.hit  <= h_eff;
                scan_reg.wild <= w_eff;
            end
            else if (shift_en)
            begin
                scan_reg <= scan_in;
            end
        end
    end

    assign scan_out = scan_reg;

endmodule

`default_nettype wire

// ----- sv/sector_layer_match_road_finder.sv -----
// Sector road finder with wildcard layers.
// Input channel s_*: one item per transfer, kind in s_tuser (load entry, hit,
// end of event). Loads and hits are accepted back to back while idle; each
// sector cell compares a hit against its own table row at once.
// Configuration port cfg_*: one register written per cycle; the user must
// write it only while idle, as the block itself does not enforce this.
// End of event: every cell latches its masks and match verdict in the same
// cycle and clears its hit mask; the verdicts then shift down the cell chain
// one sector per cycle unless the output stalls; s_tready stays low until the
// flush is done. A fired road is held back so that the final one can carry
// m_tlast; the first road leaves in the cycle after the next sector fires.
// If no sector fires, one transfer with m_tuser low and m_tlast high is sent.
// A stalled receiver (m_tready low with m_tvalid high) freezes the chain.
// Reset clears masks, road counter and configuration to its defaults; the
// module id table itself is not cleared and must be loaded before use.
`default_nettype none

module sector_layer_match_road_finder #(
    parameter int NUM_SECTORS = 64,
    parameter int MAX_LAYERS  = 16,
    parameter int MODULE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sector_index[5:0], layer_index[9:6], module_id[25:10], zero pad
    input  wire logic [31:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // road_number[31:0], road_sector[37:32], hit_layers[53:38],
    // wild_layers[69:54], zero pad
    output logic [71:0]      m_tdata,
    // road_valid[0]
    output logic             m_tuser,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    localparam int IDX_W     = $clog2(NUM_SECTORS + 1);
    localparam int LAYER_CAP = (MAX_LAYERS < 16) ? MAX_LAYERS : 16;

    // configuration
    logic [4:0]  layer_count_reg;
    logic [4:0]  allowed_misses_reg;
    logic [6:0]  sector_count_reg;
    logic [15:0] wildcard_reg;

    // control
    slmrf_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [31:0]       road_count_reg;
    logic              pend_valid_reg;
    logic [31:0]       pend_number_reg;
    logic [5:0]        pend_sector_reg;
    logic [15:0]       pend_hit_reg;
    logic [15:0]       pend_wild_reg;
    logic              out_valid_reg;
    logic              out_road_reg;
    logic              out_last_reg;
    logic [31:0]       out_number_reg;
    logic [5:0]        out_sector_reg;
    logic [15:0]       out_hit_reg;
    logic [15:0]       out_wild_reg;

    // decode
    logic              s_accept;
    slmrf_pkg::op_t    op;
    logic [5:0]        in_sector;
    logic [3:0]        in_layer;
    logic [15:0]       in_module;
    logic [MODULE_BITS-1:0] mod_cut;
    logic [MODULE_BITS-1:0] wild_cut;
    logic [4:0]        nl;
    logic [15:0]       lmask;
    logic [4:0]        need;
    logic [IDX_W-1:0]  limit;
    logic              can_step;
    logic              step;
    logic              take_head;
    logic              flush_out;
    slmrf_pkg::bcast_t bc;
    slmrf_pkg::scan_t  chain [NUM_SECTORS+1];
    slmrf_pkg::scan_t  head;

    assign s_tready  = (state_reg == slmrf_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign op        = slmrf_pkg::op_t'(s_tuser);
    assign in_sector = s_tdata[5:0];
    assign in_layer  = s_tdata[9:6];
    assign in_module = s_tdata[25:10];
    assign mod_cut   = MODULE_BITS'(32'(in_module));
    assign wild_cut  = MODULE_BITS'(32'(wildcard_reg));

    // layers in use, mask and firing threshold
    assign nl    = (layer_count_reg > 5'(LAYER_CAP)) ? 5'(LAYER_CAP) : layer_count_reg;
    assign lmask = 16'((17'd1 << nl) - 17'd1);
    assign need  = (nl > allowed_misses_reg) ? (nl - allowed_misses_reg) : 5'd0;
    assign limit = (32'(sector_count_reg) < NUM_SECTORS) ? IDX_W'(sector_count_reg)
                                                         : IDX_W'(NUM_SECTORS);

    // broadcast command
    always_comb
    begin
        bc        = '0;
        bc.wild   = (mod_cut == wild_cut);
        bc.sector = in_sector;
        bc.layer  = in_layer;
        bc.lmask  = lmask;
        bc.need   = need;
        if (s_accept)
        begin
            unique case (op)
                slmrf_pkg::OP_LOAD: bc.load = 1'b1;
                slmrf_pkg::OP_HIT:  bc.hit  = ({1'b0, in_layer} < nl);
                slmrf_pkg::OP_EOE:  bc.eoe  = 1'b1;
                default:            bc.load = 1'b0;
            endcase
        end
    end

    // row of sector cells
    assign chain[NUM_SECTORS] = '0;
    for (genvar g = 0; g < NUM_SECTORS; g++)
    begin : g_cell
        slmrf_cell #(
            .SECTOR_ID  (g),
            .MAX_LAYERS (MAX_LAYERS),
            .MODULE_BITS(MODULE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bc        (bc),
            .module_val(mod_cut),
            .shift_en  (step),
            .scan_in   (chain[g+1]),
            .scan_out  (chain[g])
        );
    end
    assign head = chain[0];

    // scan sequencer
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        can_step      = !out_valid_reg || m_tready;
        step          = 1'b0;
        flush_out     = 1'b0;
        unique case (state_reg)
            slmrf_pkg::ST_IDLE:
            begin
                if (bc.eoe)
                begin
                    state_next    = slmrf_pkg::ST_SCAN;
                    scan_idx_next = '0;
                end
            end
            slmrf_pkg::ST_SCAN:
            begin
                if (scan_idx_reg >= limit)
                begin
                    state_next = slmrf_pkg::ST_FLUSH;
                end
                else if (can_step)
                begin
                    step          = 1'b1;
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            slmrf_pkg::ST_FLUSH:
            begin
                if (can_step)
                begin
                    flush_out  = 1'b1;
                    state_next = slmrf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slmrf_pkg::ST_IDLE;
            end
        endcase
        take_head = step && head.fire;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg    <= 5'd8;
            allowed_misses_reg <= 5'd0;
            sector_count_reg   <= 7'd64;
            wildcard_reg       <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            unique case (slmrf_pkg::cfg_idx_t'(cfg_addr))
                slmrf_pkg::CFG_LAYER_COUNT:    layer_count_reg    <= cfg_wdata[4:0];
                slmrf_pkg::CFG_ALLOWED_MISSES: allowed_misses_reg <= cfg_wdata[4:0];
                slmrf_pkg::CFG_SECTOR_COUNT:   sector_count_reg   <= cfg_wdata[6:0];
                slmrf_pkg::CFG_WILDCARD:       wildcard_reg       <= cfg_wdata;
                default:                       wildcard_reg       <= wildcard_reg;
            endcase
        end
    end

    // control state, road counter, held road
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= slmrf_pkg::ST_IDLE;
            scan_idx_reg   <= '0;
            road_count_reg <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            if (take_head)
            begin
                road_count_reg <= road_count_reg + 32'd1;
                pend_valid_reg <= 1'b1;
            end
            else if (flush_out)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // held road payload
    always_ff @(posedge clk)
    begin
        if (take_head)
        begin
            pend_number_reg <= road_count_reg;
            pend_sector_reg <= 6'(scan_idx_reg);
            pend_hit_reg    <= head.hit;
            pend_wild_reg   <= head.wild;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((take_head && pend_valid_reg) || flush_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((take_head && pend_valid_reg) || (flush_out && pend_valid_reg))
        begin
            out_road_reg   <= 1'b1;
            out_last_reg   <= flush_out;
            out_number_reg <= pend_number_reg;
            out_sector_reg <= pend_sector_reg;
            out_hit_reg    <= pend_hit_reg;
            out_wild_reg   <= pend_wild_reg;
        end
        else if (flush_out)
        begin
            out_road_reg   <= 1'b0;
            out_last_reg   <= 1'b1;
            out_number_reg <= '0;
            out_sector_reg <= '0;
            out_hit_reg    <= '0;
            out_wild_reg   <= '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_road_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_wild_reg, out_hit_reg, out_sector_reg, out_number_reg};

    // no road may be held while new items are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_valid_reg)
        else $error("held road left over after scan");

    // scan pointer never runs past the sectors in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slmrf_pkg::ST_SCAN) |-> (scan_idx_reg <= limit))
        else $error("scan pointer beyond sector limit");

    // road numbers advance by one per fired road
    assert property (@(posedge clk) disable iff (!rst_n)
        (road_count_reg != $past(road_count_reg)) |->
            (road_count_reg == $past(road_count_reg) + 32'd1))
        else $error("road counter skipped");

    // an output is only loaded while the chain is scanning or flushing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |->
            ($past(state_reg) != slmrf_pkg::ST_IDLE))
        else $error("result produced while idle");

endmodule

`default_nettype wire
